/* hw/rtl/nsrs_pkg.sv */
`timescale 1ns / 1ps
package nsrs_pkg;

  // Element formats selected by the configuration register
  typedef enum logic [1:0] {
    ELEM_F64 = 2'd0,
    ELEM_F32 = 2'd1,
    ELEM_I64 = 2'd2,
    ELEM_I32 = 2'd3
  } elem_type_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned F64ExpW = 11;
  localparam int unsigned F64ManW = 52;
  localparam int unsigned F32ExpW = 8;
  localparam int unsigned F32ManW = 23;

  localparam logic [63:0] Nan64Canon = 64'h7FF8_0000_0000_0000;
  localparam logic [31:0] Nan32Canon = 32'h7FC0_0000;

  function automatic logic is_nan64(input logic [63:0] b);
    return (b[62:52] == '1) && (b[51:0] != '0);
  endfunction

  function automatic logic is_nan32(input logic [31:0] b);
    return (b[30:23] == '1) && (b[22:0] != '0);
  endfunction

endpackage

/* hw/rtl/nsrs_fadd.sv */
`timescale 1ns / 1ps
module nsrs_fadd
  import nsrs_pkg::*;
#(
  parameter int unsigned ExpW = F64ExpW,
  parameter int unsigned ManW = F64ManW
) (
  input  logic [ExpW+ManW:0] a_i,
  input  logic [ExpW+ManW:0] b_i,
  output logic [ExpW+ManW:0] sum_o
);

  localparam int unsigned W  = ExpW + ManW + 1;
  localparam int unsigned N  = ManW + 4;
  localparam int unsigned DW = $clog2(N + 1);
  localparam int unsigned XW = ExpW + 1;

  logic            swap;
  logic [W-1:0]    x, y;
  logic            sx, sy, sub;
  logic [ExpW-1:0] ex, ey, ex_eff, ey_eff, diff;
  logic [N-1:0]    mx, my, my_sh, my_al, nv, norm;
  logic [DW-1:0]   shamt, lz;
  logic            lost, found, carry, g, rs, up, ovf, sgn;
  logic [N:0]      sum;
  logic [XW-1:0]   lzx, lim, s, e_n, field;
  logic [ManW-1:0] frac;
  logic [ExpW+ManW-1:0] rounded;
  logic            a_nan, a_inf, b_inf;
  logic [W-1:0]    canon;

  // Order operands by magnitude
  always_comb begin
    swap   = b_i[W-2:0] > a_i[W-2:0];
    x      = swap ? b_i : a_i;
    y      = swap ? a_i : b_i;
    sx     = x[W-1];
    sy     = y[W-1];
    sub    = sx ^ sy;
    ex     = x[W-2:ManW];
    ey     = y[W-2:ManW];
    ex_eff = (ex == '0) ? ExpW'(1) : ex;
    ey_eff = (ey == '0) ? ExpW'(1) : ey;
    mx     = {(ex != '0), x[ManW-1:0], 3'b000};
    my     = {(ey != '0), y[ManW-1:0], 3'b000};
    diff   = ex_eff - ey_eff;
    shamt  = (XW'(diff) > XW'(N)) ? DW'(N) : DW'(diff);
  end

  // Align the smaller operand, fold shifted-out bits into sticky
  always_comb begin
    my_sh = my >> shamt;
    lost  = |(my & ~({N{1'b1}} << shamt));
    my_al = {my_sh[N-1:1], my_sh[0] | lost};
    sum   = sub ? ({1'b0, mx} - {1'b0, my_al}) : ({1'b0, mx} + {1'b0, my_al});
    carry = sum[N];
  end

  // Count leading zeros of the sum
  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!found) begin
        if (sum[i]) found = 1'b1;
        else        lz = lz + DW'(1);
      end
    end
  end

  // Normalize, limited by the exponent floor for subnormals
  always_comb begin
    lzx = XW'(lz);
    lim = XW'(ex_eff) - XW'(1);
    s   = (lzx < lim) ? lzx : lim;
    nv  = sum[N-1:0] << s;
    if (carry) begin
      norm  = {sum[N:2], sum[1] | sum[0]};
      e_n   = XW'(ex_eff) + XW'(1);
      field = e_n;
    end else begin
      norm  = nv;
      e_n   = XW'(ex_eff) - s;
      field = nv[N-1] ? e_n : '0;
    end
  end

  // Round to nearest even, pack; handle NaN, inf, overflow
  always_comb begin
    frac    = norm[N-2:3];
    g       = norm[2];
    rs      = norm[1] | norm[0];
    up      = g & (rs | frac[0]);
    ovf     = field >= {1'b0, {ExpW{1'b1}}};
    rounded = {field[ExpW-1:0], frac} + (ExpW+ManW)'(up);
    sgn     = ((sum == '0) && sub) ? 1'b0 : sx;
    canon   = {1'b0, {ExpW{1'b1}}, 1'b1, {(ManW-1){1'b0}}};
    a_nan   = (a_i[W-2:ManW] == '1) && (a_i[ManW-1:0] != '0);
    a_inf   = (a_i[W-2:ManW] == '1) && (a_i[ManW-1:0] == '0);
    b_inf   = (b_i[W-2:ManW] == '1) && (b_i[ManW-1:0] == '0);
    if (a_nan || (a_inf && b_inf && (a_i[W-1] != b_i[W-1]))) begin
      sum_o = canon;
    end else if (a_inf) begin
      sum_o = a_i;
    end else if (b_inf) begin
      sum_o = b_i;
    end else if (ovf) begin
      sum_o = {sgn, {ExpW{1'b1}}, {ManW{1'b0}}};
    end else begin
      sum_o = {sgn, rounded};
    end
  end

endmodule

/* hw/rtl/nsrs_accum.sv */
`timescale 1ns / 1ps
module nsrs_accum
  import nsrs_pkg::*;
(
  input  elem_type_e       etype_i,
  input  logic [DataW-1:0] acc_i,
  input  logic [DataW-1:0] value_i,
  output logic [DataW-1:0] sum_o
);

  logic [63:0] f64_sum;
  logic [31:0] f32_sum;
  logic [31:0] i32_sum;

  nsrs_fadd #(.ExpW(F64ExpW), .ManW(F64ManW)) u_fadd64 (
    .a_i  (acc_i),
    .b_i  (value_i),
    .sum_o(f64_sum)
  );

  nsrs_fadd #(.ExpW(F32ExpW), .ManW(F32ManW)) u_fadd32 (
    .a_i  (acc_i[31:0]),
    .b_i  (value_i[31:0]),
    .sum_o(f32_sum)
  );

  assign i32_sum = acc_i[31:0] + value_i[31:0];

  // Select the sum for the format; drop float NaN elements
  always_comb begin
    case (etype_i)
      ELEM_F64: sum_o = is_nan64(value_i) ? acc_i : f64_sum;
      ELEM_F32: sum_o = is_nan32(value_i[31:0]) ? {32'd0, acc_i[31:0]} : {32'd0, f32_sum};
      ELEM_I64: sum_o = acc_i + value_i;
      ELEM_I32: sum_o = {32'd0, i32_sum};
      default:  sum_o = acc_i;
    endcase
  end

endmodule

/* hw/rtl/nan_skipping_row_sum.sv */
`timescale 1ns / 1ps
// Elements are registered in stage one, row results in the result register.
// Throughput: one element per cycle; the accumulator add is combinational.
// Elements that end no row keep flowing while a result waits; a row end stalls.
// Reset (async, active low): accumulator to +0, format to float64, no result.
module nan_skipping_row_sum
  import nsrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [DataW-1:0] value_bits_i,
  input  logic             last_of_row_i,
  input  logic             empty_row_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] sum_bits_o
);

  elem_type_e       etype_q;
  logic             s1_valid_q, s1_last_q, s1_empty_q;
  logic [DataW-1:0] s1_value_q;
  logic [DataW-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_sum_q, out_sum_d;
  logic [DataW-1:0] step_sum;
  logic             advance, in_fire, s2_fire;

  assign cfg_ready_o = 1'b1;

  // Hold stage one only when it would emit into a blocked output
  assign advance    = !(s1_valid_q && (s1_last_q || s1_empty_q) && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s2_fire    = s1_valid_q && advance;

  nsrs_accum u_accum (
    .etype_i(etype_q),
    .acc_i  (acc_q),
    .value_i(s1_value_q),
    .sum_o  (step_sum)
  );

  // Update accumulator and result register
  always_comb begin
    acc_d       = acc_q;
    out_sum_d   = out_sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s2_fire) begin
      if (s1_empty_q) begin
        acc_d       = '0;
        out_sum_d   = '0;
        out_valid_d = 1'b1;
      end else if (s1_last_q) begin
        acc_d       = '0;
        out_sum_d   = step_sum;
        out_valid_d = 1'b1;
      end else begin
        acc_d = step_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q     <= ELEM_F64;
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) etype_q <= elem_type_e'(cfg_data_i);
      if (in_fire)      s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture input transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_value_q <= value_bits_i;
      s1_last_q  <= last_of_row_i;
      s1_empty_q <= empty_row_i;
    end
    out_sum_q <= out_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign sum_bits_o  = out_sum_q;

endmodule

/* hw/rtl/nsrs_checker.sv */
`timescale 1ns / 1ps
module nsrs_checker
  import nsrs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             last_of_row_i,
  input logic             empty_row_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [DataW-1:0] sum_bits_o
);

  // A stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input back-pressure only comes from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A fresh result comes from a row-ending transaction that passed stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (last_of_row_i || empty_row_i), 2))
    else $error("result without a row-ending transaction");

  // An empty row yields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(in_valid_i && !in_stall_o && empty_row_i, 2)
      |-> sum_bits_o == '0)
    else $error("empty row gave nonzero sum");

endmodule

bind nan_skipping_row_sum nsrs_checker u_nsrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_of_row_i(last_of_row_i),
  .empty_row_i  (empty_row_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sum_bits_o   (sum_bits_o)
);
